// ----- rtl/core/assert_macros.svh -----
// Assertion helpers; expect clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/core/itss_pkg.sv -----
`default_nettype none

package itss_pkg;

  localparam logic [2:0] OPEN_LEN  = 3'd5;
  localparam logic [2:0] CLOSE_LEN = 3'd6;

  localparam logic [7:0] CH_LB    = 8'h5B;
  localparam logic [7:0] CH_RB    = 8'h5D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_G     = 8'h67;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       kind_a;
    logic [2:0] rep1;
    logic       has_data;
    logic [7:0] data;
    logic       end1;
    logic       kind_b;
    logic [2:0] rep2;
    logic       end2;
    logic       mark;
    logic       last;
  } cmd_t;

  // Character idx of the tag in force for the given mode.
  function automatic logic [7:0] tag_char(input logic mode, input logic [2:0] idx);
    logic [7:0] c;
    c = CH_LB;
    if (mode) begin
      case (idx)
        3'd0: c = CH_LB;
        3'd1: c = CH_SLASH;
        3'd2: c = CH_I;
        3'd3: c = CH_M;
        3'd4: c = CH_G;
        3'd5: c = CH_RB;
        default: c = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0: c = CH_LB;
        3'd1: c = CH_I;
        3'd2: c = CH_M;
        3'd3: c = CH_G;
        3'd4: c = CH_RB;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/itss_if.sv -----
`default_nettype none

interface itss_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       msg_last;

  modport source (output valid, output data_byte, output msg_last, input ready);
  modport sink   (input valid, input data_byte, input msg_last, output ready);
endinterface

interface itss_seg_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       seg_kind;
  logic       seg_end;
  logic       msg_end;
  logic       run_last;

  modport source (output valid, output has_byte, output out_byte, output seg_kind,
                  output seg_end, output msg_end, output run_last, input ready);
  modport sink   (input valid, input has_byte, input out_byte, input seg_kind,
                  input seg_end, input msg_end, input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/itss_front.sv -----
`default_nettype none

`include "assert_macros.svh"

module itss_front (
  input  wire logic         clk,
  input  wire logic         rst,
  itss_msg_if.sink          msg,
  output itss_pkg::cmd_t    cmd,
  output logic              push,
  input  wire logic         full
);
  import itss_pkg::*;

  logic       in_image;
  logic [2:0] match_len;
  logic       seg_nonempty;

  logic       in_image_next;
  logic [2:0] match_len_next;
  logic       seg_nonempty_next;

  logic       fire;
  logic [2:0] tlen;
  logic [2:0] ml;
  logic [2:0] ml1;
  logic       hit;
  logic       state_idle;

  assign msg.ready  = !full;
  assign fire       = msg.valid && msg.ready;
  assign state_idle = !in_image && (match_len == 3'd0) && !seg_nonempty;

  always_comb begin
    tlen = in_image ? CLOSE_LEN : OPEN_LEN;
    ml   = (match_len >= tlen) ? 3'd0 : match_len;
    ml1  = ml + 3'd1;
    hit  = (msg.data_byte == tag_char(in_image, ml));

    cmd               = '0;
    cmd.kind_a        = in_image;
    in_image_next     = in_image;
    match_len_next    = match_len;
    seg_nonempty_next = seg_nonempty;

    if (hit) begin
      if (ml1 == tlen) begin
        cmd.end1          = in_image || seg_nonempty;
        in_image_next     = !in_image;
        seg_nonempty_next = 1'b0;
        match_len_next    = 3'd0;
      end else begin
        match_len_next = ml1;
      end
    end else begin
      cmd.rep1 = ml;
      if (ml != 3'd0) seg_nonempty_next = 1'b1;
      if (msg.data_byte == CH_LB) begin
        match_len_next = 3'd1;
      end else begin
        cmd.has_data      = 1'b1;
        cmd.data          = msg.data_byte;
        seg_nonempty_next = 1'b1;
        match_len_next    = 3'd0;
      end
    end

    cmd.kind_b = in_image_next;
    if (msg.msg_last) begin
      cmd.last = 1'b1;
      cmd.rep2 = match_len_next;
      cmd.end2 = seg_nonempty_next || (match_len_next != 3'd0);
      cmd.mark = (cmd.rep1 == 3'd0) && !cmd.has_data && !cmd.end1 &&
                 (match_len_next == 3'd0) && !cmd.end2;
      in_image_next     = 1'b0;
      match_len_next    = 3'd0;
      seg_nonempty_next = 1'b0;
    end

    push = fire && ((cmd.rep1 != 3'd0) || cmd.has_data || cmd.end1 || cmd.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_image     <= 1'b0;
      match_len    <= 3'd0;
      seg_nonempty <= 1'b0;
    end else if (fire) begin
      in_image     <= in_image_next;
      match_len    <= match_len_next;
      seg_nonempty <= seg_nonempty_next;
    end
  end

  `ASSERT_NEXT(a_last_clears, fire && msg.msg_last, state_idle, "state kept past message end")

endmodule

`default_nettype wire

// ----- rtl/core/itss_queue.sv -----
`default_nettype none

`include "assert_macros.svh"

module itss_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire itss_pkg::cmd_t  wr_cmd,
  output logic                 full,
  input  wire logic            pop,
  output itss_pkg::cmd_t       head,
  output logic                 empty
);
  import itss_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + QAW'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + QAW'(1);
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")
  `ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

`default_nettype wire

// ----- rtl/core/itss_back.sv -----
`default_nettype none

`include "assert_macros.svh"

module itss_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire itss_pkg::cmd_t  head,
  input  wire logic            empty,
  output logic                 pop,
  itss_seg_if.source           seg
);
  import itss_pkg::*;

  logic [2:0] pos;
  logic [2:0] c1, c2, c3, c4, c5, total;
  logic       load;
  logic       last_el;
  logic       has_b;
  logic [7:0] byte_b;
  logic       kind_b;
  logic       end_b;

  always_comb begin
    c1    = head.rep1;
    c2    = c1 + {2'b00, head.has_data};
    c3    = c2 + {2'b00, head.end1};
    c4    = c3 + head.rep2;
    c5    = c4 + {2'b00, head.end2};
    total = c5 + {2'b00, head.mark};

    has_b  = 1'b0;
    byte_b = 8'h00;
    end_b  = 1'b0;
    kind_b = head.kind_b;
    if (pos < c1) begin
      has_b  = 1'b1;
      byte_b = tag_char(head.kind_a, pos);
      kind_b = head.kind_a;
    end else if (pos < c2) begin
      has_b  = 1'b1;
      byte_b = head.data;
      kind_b = head.kind_a;
    end else if (pos < c3) begin
      end_b  = 1'b1;
      kind_b = head.kind_a;
    end else if (pos < c4) begin
      has_b  = 1'b1;
      byte_b = tag_char(head.kind_b, pos - c3);
    end else if (pos < c5) begin
      end_b = 1'b1;
    end

    last_el = (pos == total - 3'd1);
    load    = !empty && (!seg.valid || seg.ready);
    pop     = load && last_el;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 3'd0;
      seg.valid <= 1'b0;
    end else begin
      if (load) begin
        pos       <= last_el ? 3'd0 : pos + 3'd1;
        seg.valid <= 1'b1;
      end else if (seg.ready) begin
        seg.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg.has_byte <= has_b;
      seg.out_byte <= byte_b;
      seg.seg_kind <= kind_b;
      seg.seg_end  <= end_b;
      seg.run_last <= last_el;
      seg.msg_end  <= last_el && head.last;
    end
  end

  `ASSERT_ALWAYS(a_pos_in_range, empty || (pos < total), "result index past command")
  `ASSERT_ALWAYS(a_end_no_byte, !(seg.valid && seg.has_byte && seg.seg_end), "segment end with byte")

endmodule

`default_nettype wire

// ----- rtl/core/image_tag_segment_splitter_core.sv -----
// Image tag segment splitter.
// msg (sink): one message byte per transfer, data_byte plus msg_last on the final byte.
// seg (source): one result per transfer: has_byte/out_byte, seg_kind (0 text, 1 image),
//   seg_end, msg_end on the last result of a message, run_last on the last result of
//   the byte that caused it.
// The front matches [img] / [/img], holds partial tags and turns each byte with results
//   into a command; a 4-deep command queue feeds the back, which expands a command into
//   one to seven results in its output register, one per cycle while seg.ready is high.
// With an idle back, the first result of a byte is written into the queue and then into
//   the output register before it is valid on seg.
// Throughput: one byte per cycle while seg.ready is high and each byte yields at most one
//   result; a byte with more results holds the back while the queue fills behind it.
// Bytes inside a partial tag yield nothing until the tag completes or fails.
// Reset (rst, synchronous): text mode, no partial tag, queue empty, seg.valid low.
// When seg.ready is low the output register holds its result; the queue keeps
//   taking bytes until it is full, then msg.ready drops.
`default_nettype none

module image_tag_segment_splitter_core (
  input  wire logic  clk,
  input  wire logic  rst,
  itss_msg_if.sink   msg,
  itss_seg_if.source seg
);
  import itss_pkg::*;

  cmd_t wr_cmd;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;

  itss_front u_front (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg),
    .cmd  (wr_cmd),
    .push (push),
    .full (full)
  );

  itss_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (full),
    .pop    (pop),
    .head   (head),
    .empty  (empty)
  );

  itss_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .seg   (seg)
  );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

import itss_pkg::*;

typedef enum logic {KIND_TEXT = 1'b0, KIND_IMAGE = 1'b1} seg_kind_e;

typedef struct packed {
  logic       has_byte;
  logic [7:0] out_byte;
  logic       seg_kind;
  logic       seg_end;
  logic       msg_end;
  logic       run_last;
} seg_result_t;

// Byte idx of the tag matched in the given mode: [img] in text, [/img] in image.
function automatic logic [7:0] tag_byte(input seg_kind_e mode, input int idx);
  logic [7:0] seq [6];
  if (mode == KIND_IMAGE) begin
    seq = '{CH_LB, CH_SLASH, CH_I, CH_M, CH_G, CH_RB};
  end else begin
    seq = '{CH_LB, CH_I, CH_M, CH_G, CH_RB, 8'h00};
  end
  return seq[idx];
endfunction

function automatic int tag_length(input seg_kind_e mode);
  return (mode == KIND_IMAGE) ? int'(CLOSE_LEN) : int'(OPEN_LEN);
endfunction

class splitter_scoreboard;
  seg_result_t segment_results_due[$];
  seg_result_t byte_burst[$];
  seg_kind_e   mode;
  logic [2:0]  tag_matched;
  bit          seg_open;
  int          errors;
  int          bytes_seen;
  int          msgs_seen;
  int          results_seen;
  int          closes [2];
  int          max_burst;

  function new();
    mode = KIND_TEXT;
    tag_matched = 3'd0;
    seg_open = 1'b0;
  endfunction

  function void emit(input bit has, input logic [7:0] b, input bit fin);
    seg_result_t r;
    r.has_byte = has;
    r.out_byte = has ? b : 8'h00;
    r.seg_kind = mode;
    r.seg_end  = fin;
    r.msg_end  = 1'b0;
    r.run_last = 1'b0;
    if (has) seg_open = 1'b1;
    byte_burst = {byte_burst, r};
  endfunction

  // Accepted message byte: work out the results it causes.
  function void take_byte(input logic [7:0] b, input logic last);
    int tlen;
    int ml;
    tlen = tag_length(mode);
    ml = tag_matched;
    byte_burst.delete();
    bytes_seen++;
    if (ml >= tlen) ml = 0;
    if (b == tag_byte(mode, ml)) begin
      ml++;
      if (ml == tlen) begin
        if (mode == KIND_IMAGE || seg_open) emit(1'b0, 8'h00, 1'b1);
        mode = (mode == KIND_IMAGE) ? KIND_TEXT : KIND_IMAGE;
        seg_open = 1'b0;
        ml = 0;
      end
    end else begin
      for (int i = 0; i < ml; i++) emit(1'b1, tag_byte(mode, i), 1'b0);
      if (b == CH_LB) begin
        ml = 1;
      end else begin
        emit(1'b1, b, 1'b0);
        ml = 0;
      end
    end
    if (last) begin
      msgs_seen++;
      for (int i = 0; i < ml; i++) emit(1'b1, tag_byte(mode, i), 1'b0);
      if (seg_open) emit(1'b0, 8'h00, 1'b1);
      if (byte_burst.size() == 0) emit(1'b0, 8'h00, 1'b0);
      byte_burst[byte_burst.size()-1].msg_end = 1'b1;
      mode = KIND_TEXT;
      seg_open = 1'b0;
      ml = 0;
    end
    tag_matched = ml[2:0];
    if (byte_burst.size() > 0) byte_burst[byte_burst.size()-1].run_last = 1'b1;
    if (byte_burst.size() > max_burst) max_burst = byte_burst.size();
    segment_results_due = {segment_results_due, byte_burst};
  endfunction

  function void check_segment_result(input seg_result_t got);
    seg_result_t want;
    results_seen++;
    if (got.seg_end === 1'b1) closes[got.seg_kind]++;
    if (segment_results_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected has=%0b byte=%02h kind=%0b end=%0b mend=%0b rlast=%0b",
               $time, got.has_byte, got.out_byte, got.seg_kind, got.seg_end, got.msg_end,
               got.run_last);
      return;
    end
    want = segment_results_due.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: mismatch expected has=%0b byte=%02h kind=%0b end=%0b mend=%0b rlast=%0b",
               $time, want.has_byte, want.out_byte, want.seg_kind, want.seg_end, want.msg_end,
               want.run_last);
      $display("%0t:          actual has=%0b byte=%02h kind=%0b end=%0b mend=%0b rlast=%0b",
               $time, got.has_byte, got.out_byte, got.seg_kind, got.seg_end, got.msg_end,
               got.run_last);
    end
  endfunction

  function int pending();
    return segment_results_due.size();
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  int   cycle_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   items_sent = 0;
  int   hold_len = 0;
  int   hold_id = 0;
  int   hold_served = 0;
  int   hold_left = 0;

  splitter_scoreboard sb = new();

  itss_msg_if msg_bus();
  itss_seg_if seg_bus();

  image_tag_segment_splitter_core DUT (
    .clk (clk),
    .rst (rst),
    .msg (msg_bus),
    .seg (seg_bus)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_cnt, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    seg_result_t got;
    if (!rst && seg_bus.valid === 1'b1 && seg_bus.ready === 1'b1) begin
      got.has_byte = seg_bus.has_byte;
      got.out_byte = seg_bus.out_byte;
      got.seg_kind = seg_bus.seg_kind;
      got.seg_end  = seg_bus.seg_end;
      got.msg_end  = seg_bus.msg_end;
      got.run_last = seg_bus.run_last;
      sb.check_segment_result(got);
    end
  end

  // Result side back-pressure; a long hold is requested through hold_id.
  initial begin
    seg_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_id != hold_served) begin
        hold_served = hold_id;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        seg_bus.ready <= 1'b0;
      end else begin
        seg_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      msg_bus.valid <= 1'b0;
      @(negedge clk);
    end
    msg_bus.valid     <= 1'b1;
    msg_bus.data_byte <= b;
    msg_bus.msg_last  <= last;
    do @(posedge clk); while (msg_bus.ready !== 1'b1);
    sb.take_byte(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && (i == s.len() - 1));
  endtask

  task automatic drain();
    msg_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly tags, broken tags and stray brackets mixed with random text.
  task automatic send_random_msg(input int len_max);
    logic [7:0] msg_q[$];
    int         target;
    int         pick;
    int         cut;
    bit         noise;
    seg_kind_e  which;
    target = $urandom_range(1, len_max);
    noise = ($urandom_range(0, 5) == 0);
    while (msg_q.size() < target) begin
      pick = noise ? 15 : $urandom_range(0, 15);
      which = (pick % 2 == 1) ? KIND_IMAGE : KIND_TEXT;
      if (pick <= 5) begin
        for (int i = 0; i < tag_length(which); i++) msg_q = {msg_q, tag_byte(which, i)};
      end else if (pick <= 7) begin
        cut = $urandom_range(1, tag_length(which) - 1);
        for (int i = 0; i < cut; i++) msg_q = {msg_q, tag_byte(which, i)};
      end else if (pick == 8) begin
        msg_q = {msg_q, CH_LB};
      end else begin
        msg_q = {msg_q, 8'($urandom_range(0, 255))};
      end
    end
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
    int start;
    start = items_sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (items_sent - start < n_items) send_random_msg(16);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    msg_bus.valid = 1'b0;
    msg_bus.data_byte = 8'h00;
    msg_bus.msg_last = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // empty text before a tag, empty image segment, end with nothing left to emit
    send_text("[img][/img][img]", 1'b1);
    // failing bracket, zero byte, broken close tag at message end (seven results)
    send_text("[[", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("[img][/img", 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    run_phase(55, 0, 0);
    run_phase(50, 88, 0);
    run_phase(50, 0, 88);
    run_phase(50, 38, 38);

    // Long output hold while bytes keep coming, so the input side backs up.
    hold_len = 150;
    hold_id++;
    run_phase(45, 0, 0);

    recv_stall_pct = 0;
    repeat (20) @(negedge clk);

    $display("Sent %0d bytes in %0d messages across five handshake mixes, one long output hold.",
             sb.bytes_seen, sb.msgs_seen);
    $display("Checked %0d results: %0d text and %0d image segments closed, up to %0d per byte.",
             sb.results_seen, sb.closes[KIND_TEXT], sb.closes[KIND_IMAGE], sb.max_burst);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
